// File: src/sexpr_lexer_macros.svh
// Assertion macros used by the lexer checker.
`ifndef SEXPR_LEXER_MACROS_SVH
`define SEXPR_LEXER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sexpr_lexer check failed");

// Next-cycle implication, held off while reset is asserted.
`define SL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sexpr_lexer check failed");

`endif

// File: src/sexpr_pkg.sv
// Types and constants shared by the s-expression lexer modules.
`default_nettype none

package sexpr_pkg;

    localparam int RUN_MAX     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [1:0] EV_CONTENT   = 2'd0;
    localparam logic [1:0] EV_CLOSE     = 2'd1;
    localparam logic [1:0] EV_LINE_DONE = 2'd2;

    localparam logic [2:0] TK_SYMBOL     = 3'd0;
    localparam logic [2:0] TK_STRING     = 3'd1;
    localparam logic [2:0] TK_LBRACKET   = 3'd2;
    localparam logic [2:0] TK_RBRACKET   = 3'd3;
    localparam logic [2:0] TK_APOSTROPHE = 3'd4;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'b001,
        MODE_STRING  = 3'b010,
        MODE_COMMENT = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  esc;
        logic  has;
    } lex_state_t;

    typedef struct packed {
        logic       last;
        logic [7:0] content_byte;
        logic [2:0] token_kind;
        logic [1:0] event_kind;
    } result_t;

    typedef struct packed {
        logic [1:0]               cnt;
        result_t [RUN_MAX-1:0]    res;
    } run_t;

endpackage

`default_nettype wire

// File: src/sexpr_decode.sv
// Per-item lexer decode: results caused by one item and the next lexer state.
`default_nettype none

module sexpr_decode (
    input  wire logic                  opcode,
    input  wire logic [7:0]            char_byte,
    input  wire sexpr_pkg::lex_state_t cur,
    output sexpr_pkg::lex_state_t      nxt,
    output sexpr_pkg::run_t            run
);

    function automatic sexpr_pkg::result_t mk(input logic [1:0] ev, input logic [2:0] tk,
                                              input logic [7:0] b);
        sexpr_pkg::result_t r;
        r.last         = 1'b0;
        r.event_kind   = ev;
        r.token_kind   = tk;
        r.content_byte = b;
        return r;
    endfunction

    logic       is_space;
    logic       is_single;
    logic [2:0] single_tk;

    always_comb begin
        is_space  = (char_byte == sexpr_pkg::CH_SPACE) ||
                    ((char_byte >= sexpr_pkg::CH_TAB) && (char_byte <= sexpr_pkg::CH_CR));
        is_single = (char_byte == sexpr_pkg::CH_LPAREN) ||
                    (char_byte == sexpr_pkg::CH_RPAREN) ||
                    (char_byte == sexpr_pkg::CH_QUOTE);
        if (char_byte == sexpr_pkg::CH_LPAREN) begin
            single_tk = sexpr_pkg::TK_LBRACKET;
        end else if (char_byte == sexpr_pkg::CH_RPAREN) begin
            single_tk = sexpr_pkg::TK_RBRACKET;
        end else begin
            single_tk = sexpr_pkg::TK_APOSTROPHE;
        end
    end

    always_comb begin
        nxt     = cur;
        run.cnt = 2'd0;
        run.res = '0;
        if (opcode == sexpr_pkg::OP_EOL) begin
            if (cur.has) begin
                run.res[run.cnt] = mk(sexpr_pkg::EV_CLOSE,
                    (cur.mode == sexpr_pkg::MODE_STRING) ? sexpr_pkg::TK_STRING
                                                         : sexpr_pkg::TK_SYMBOL, 8'd0);
                run.cnt = run.cnt + 2'd1;
            end
            run.res[run.cnt] = mk(sexpr_pkg::EV_LINE_DONE, sexpr_pkg::TK_SYMBOL, 8'd0);
            run.cnt  = run.cnt + 2'd1;
            nxt.mode = sexpr_pkg::MODE_NORMAL;
            nxt.esc  = 1'b0;
            nxt.has  = 1'b0;
        end else begin
            case (cur.mode)
                sexpr_pkg::MODE_STRING: begin
                    if (char_byte == sexpr_pkg::CH_BACKSLASH && !cur.esc) begin
                        nxt.esc = 1'b1;
                    end else if (char_byte == sexpr_pkg::CH_DQUOTE && !cur.esc) begin
                        run.res[0] = mk(sexpr_pkg::EV_CLOSE, sexpr_pkg::TK_STRING, 8'd0);
                        run.cnt    = 2'd1;
                        nxt.mode   = sexpr_pkg::MODE_NORMAL;
                        nxt.has    = 1'b0;
                    end else begin
                        run.res[0] = mk(sexpr_pkg::EV_CONTENT, sexpr_pkg::TK_STRING,
                                        char_byte);
                        run.cnt    = 2'd1;
                        nxt.esc    = 1'b0;
                        nxt.has    = 1'b1;
                    end
                end
                sexpr_pkg::MODE_NORMAL: begin
                    if (is_single || is_space || char_byte == sexpr_pkg::CH_SEMICOLON ||
                        char_byte == sexpr_pkg::CH_DQUOTE) begin
                        // close any pending symbol first
                        if (cur.has) begin
                            run.res[0] = mk(sexpr_pkg::EV_CLOSE, sexpr_pkg::TK_SYMBOL, 8'd0);
                            run.cnt    = 2'd1;
                            nxt.has    = 1'b0;
                        end
                        if (is_single) begin
                            run.res[run.cnt] = mk(sexpr_pkg::EV_CONTENT, single_tk, char_byte);
                            run.cnt = run.cnt + 2'd1;
                            run.res[run.cnt] = mk(sexpr_pkg::EV_CLOSE, single_tk, 8'd0);
                            run.cnt = run.cnt + 2'd1;
                        end else if (char_byte == sexpr_pkg::CH_SEMICOLON) begin
                            nxt.mode = sexpr_pkg::MODE_COMMENT;
                        end else if (char_byte == sexpr_pkg::CH_DQUOTE) begin
                            nxt.mode = sexpr_pkg::MODE_STRING;
                            nxt.esc  = 1'b0;
                        end
                    end else begin
                        run.res[0] = mk(sexpr_pkg::EV_CONTENT, sexpr_pkg::TK_SYMBOL, char_byte);
                        run.cnt    = 2'd1;
                        nxt.has    = 1'b1;
                    end
                end
                default: begin
                    // comment: drop the byte
                end
            endcase
        end
        for (int i = 0; i < sexpr_pkg::RUN_MAX; i++) begin
            run.res[i].last = (run.cnt != 2'd0) && (2'(i) == run.cnt - 2'd1);
        end
    end

endmodule

`default_nettype wire

// File: src/sexpr_lexer.sv
// Results are written into the registered result queue when their item is accepted.
// Throughput: one item per cycle while each item gives at most one result and the
// output is not stalled; an item that gives two or three results holds the input
// until the single-entry-per-cycle drain of the four-entry result queue makes room.
// Reset: synchronous, active low; clears lexer mode, escape, token flag and the queue.
`default_nettype none

module sexpr_lexer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_byte
    input  wire logic       s_tuser,   // [0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] content_byte
    output logic [4:0]      m_tuser,   // [1:0] event_kind, [4:2] token_kind
    output logic            m_tlast    // last_of_run
);

    sexpr_pkg::lex_state_t state_reg, state_next;
    sexpr_pkg::run_t       run;

    sexpr_pkg::result_t                   queue_reg [sexpr_pkg::QUEUE_DEPTH];
    logic [sexpr_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [sexpr_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [sexpr_pkg::QCNT_W-1:0]         count_reg, count_next;

    logic s_accept;
    logic m_accept;

    sexpr_decode u_decode (
        .opcode    (s_tuser),
        .char_byte (s_tdata),
        .cur       (state_reg),
        .nxt       (state_next),
        .run       (run)
    );

    // room for a full run even if nothing drains this cycle; hold off during reset
    assign s_tready = aresetn &&
                      (count_reg <= sexpr_pkg::QCNT_W'(sexpr_pkg::QUEUE_DEPTH -
                                                       sexpr_pkg::RUN_MAX));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_accept = m_tvalid && m_tready;

    assign m_tdata  = queue_reg[rd_ptr_reg].content_byte;
    assign m_tuser  = {queue_reg[rd_ptr_reg].token_kind, queue_reg[rd_ptr_reg].event_kind};
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (s_accept) begin
            wr_ptr_next = wr_ptr_reg + sexpr_pkg::QPTR_W'(run.cnt);
            count_next  = count_next + sexpr_pkg::QCNT_W'(run.cnt);
        end
        if (m_accept) begin
            rd_ptr_next = rd_ptr_reg + sexpr_pkg::QPTR_W'(1);
            count_next  = count_next - sexpr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode <= sexpr_pkg::MODE_NORMAL;
            state_reg.esc  <= 1'b0;
            state_reg.has  <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < sexpr_pkg::RUN_MAX; i++) begin
            if (s_accept && (2'(i) < run.cnt)) begin
                queue_reg[wr_ptr_reg + sexpr_pkg::QPTR_W'(i)] <= run.res[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: src/sexpr_lexer_chk.sv
// Port-level checker for the s-expression lexer, bound to the top level.
`default_nettype none
`include "sexpr_lexer_macros.svh"

module sexpr_lexer_chk (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [4:0] m_tuser,
    input wire logic       m_tlast
);

    // a stalled result transaction stays offered
    `SL_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // line done always ends the run of its item
    `SL_ASSERT_NOW(a_done_last, aclk, aresetn,
        m_tvalid && m_tuser[1:0] == sexpr_pkg::EV_LINE_DONE, m_tlast)

    // close events carry no byte
    `SL_ASSERT_NOW(a_close_zero, aclk, aresetn,
        m_tvalid && m_tuser[1:0] == sexpr_pkg::EV_CLOSE, m_tdata == 8'd0)

    // a left bracket token's content is the bracket itself
    `SL_ASSERT_NOW(a_lbracket_byte, aclk, aresetn,
        m_tvalid && m_tuser[1:0] == sexpr_pkg::EV_CONTENT &&
        m_tuser[4:2] == sexpr_pkg::TK_LBRACKET, m_tdata == sexpr_pkg::CH_LPAREN)

endmodule

bind sexpr_lexer sexpr_lexer_chk u_sexpr_lexer_chk (.*);

`default_nettype wire

// File: tb/tb_sexpr_lexer.sv
// Self-checking testbench for the s-expression lexer: directed and random lines, random stalls.
`default_nettype none

module tb_sexpr_lexer;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 260;
    localparam int LONG_HOLD     = 120;
    localparam int REPORT_LIMIT  = 10;

    // Token scoreboard: tracks the lexer state and holds the events each byte should produce.
    class lex_scoreboard;
        sexpr_pkg::mode_t   mode;
        logic               esc;
        logic               has;
        sexpr_pkg::result_t expected_q[$];
        int                 mismatches;
        int                 items_seen;

        function new();
            mode = sexpr_pkg::MODE_NORMAL;
            esc = 1'b0;
            has = 1'b0;
            mismatches = 0;
            items_seen = 0;
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == sexpr_pkg::CH_SPACE ||
                   (c >= sexpr_pkg::CH_TAB && c <= sexpr_pkg::CH_CR);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_event(logic [1:0] ev, logic [2:0] tk, logic [7:0] b);
            sexpr_pkg::result_t r;
            r.event_kind = ev;
            r.token_kind = tk;
            r.content_byte = b;
            r.last = 1'b0;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void close_symbol();
            if (has) begin
                push_event(sexpr_pkg::EV_CLOSE, sexpr_pkg::TK_SYMBOL, 8'h00);
                has = 1'b0;
            end
        endfunction

        function void note_item(logic op, logic [7:0] c);
            int old_size;
            logic [2:0] tk;
            sexpr_pkg::result_t r;
            old_size = expected_q.size();
            items_seen++;
            if (op == sexpr_pkg::OP_EOL) begin
                if (has)
                    push_event(sexpr_pkg::EV_CLOSE,
                               (mode == sexpr_pkg::MODE_STRING) ? sexpr_pkg::TK_STRING
                                                                : sexpr_pkg::TK_SYMBOL,
                               8'h00);
                // line-done carries a zero token kind
                push_event(sexpr_pkg::EV_LINE_DONE, sexpr_pkg::TK_SYMBOL, 8'h00);
                mode = sexpr_pkg::MODE_NORMAL;
                esc = 1'b0;
                has = 1'b0;
            end else if (mode == sexpr_pkg::MODE_STRING) begin
                if (c == sexpr_pkg::CH_BACKSLASH && !esc) begin
                    esc = 1'b1;
                end else if (c == sexpr_pkg::CH_DQUOTE && !esc) begin
                    push_event(sexpr_pkg::EV_CLOSE, sexpr_pkg::TK_STRING, 8'h00);
                    mode = sexpr_pkg::MODE_NORMAL;
                    has = 1'b0;
                end else begin
                    push_event(sexpr_pkg::EV_CONTENT, sexpr_pkg::TK_STRING, c);
                    esc = 1'b0;
                    has = 1'b1;
                end
            end else if (mode == sexpr_pkg::MODE_NORMAL) begin
                if (c == sexpr_pkg::CH_LPAREN || c == sexpr_pkg::CH_RPAREN ||
                    c == sexpr_pkg::CH_QUOTE) begin
                    tk = (c == sexpr_pkg::CH_LPAREN) ? sexpr_pkg::TK_LBRACKET
                       : (c == sexpr_pkg::CH_RPAREN) ? sexpr_pkg::TK_RBRACKET
                                                     : sexpr_pkg::TK_APOSTROPHE;
                    close_symbol();
                    push_event(sexpr_pkg::EV_CONTENT, tk, c);
                    push_event(sexpr_pkg::EV_CLOSE, tk, 8'h00);
                end else if (c == sexpr_pkg::CH_SEMICOLON) begin
                    close_symbol();
                    mode = sexpr_pkg::MODE_COMMENT;
                end else if (c == sexpr_pkg::CH_DQUOTE) begin
                    close_symbol();
                    mode = sexpr_pkg::MODE_STRING;
                    esc = 1'b0;
                    has = 1'b0;
                end else if (is_blank(c)) begin
                    close_symbol();
                end else begin
                    push_event(sexpr_pkg::EV_CONTENT, sexpr_pkg::TK_SYMBOL, c);
                    has = 1'b1;
                end
            end
            // flag the final event of this transaction
            if (expected_q.size() > old_size) begin
                r = expected_q[expected_q.size() - 1];
                r.last = 1'b1;
                expected_q[expected_q.size() - 1] = r;
            end
        endfunction

        function void check_event(logic [7:0] tdata, logic [4:0] tuser, logic tlast);
            sexpr_pkg::result_t got;
            sexpr_pkg::result_t want;
            got.event_kind = tuser[1:0];
            got.token_kind = tuser[4:2];
            got.content_byte = tdata;
            got.last = tlast;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected event: ev=%0d tk=%0d byte=%02h last=%0b",
                             got.event_kind, got.token_kind, got.content_byte, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.event_kind !== want.event_kind || got.token_kind !== want.token_kind ||
                got.content_byte !== want.content_byte || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("event mismatch: expected ev=%0d tk=%0d byte=%02h last=%0b,",
                             want.event_kind, want.token_kind, want.content_byte, want.last,
                             " got ev=%0d tk=%0d byte=%02h last=%0b",
                             got.event_kind, got.token_kind, got.content_byte, got.last);
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = sexpr_pkg::OP_BYTE;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    lex_scoreboard sb = new();
    bit  no_idle = 1'b0;
    int  items_sent = 0;
    int  cycles = 0;

    sexpr_lexer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sample both channels at the edge; drivers only change after it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_event(m_tdata, m_tuser, m_tlast);
        end
    end

    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin : result_sink
        int hold;
        bit held_long;
        hold = 0;
        held_long = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_long && sb.items_seen >= 40) begin
                // back up the result queue so the input stalls
                held_long = 1'b1;
                hold = LONG_HOLD;
            end else if (hold == 0 && !no_idle && $urandom_range(0, 99) < 30) begin
                hold = stall_len();
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] c);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : stall_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [7:0] symbol_byte();
        logic [7:0] c;
        do begin
            c = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(8'h61, 8'h7A));
        end while (c == sexpr_pkg::CH_LPAREN || c == sexpr_pkg::CH_RPAREN ||
                   c == sexpr_pkg::CH_QUOTE || c == sexpr_pkg::CH_SEMICOLON ||
                   c == sexpr_pkg::CH_DQUOTE || lex_scoreboard::is_blank(c));
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? sexpr_pkg::CH_SPACE : 8'(sexpr_pkg::CH_TAB + r[2:0]);
    endfunction

    task automatic send_string();
        int n;
        logic [7:0] c;
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        n = $urandom_range(0, 4);
        repeat (n) begin
            c = 8'($urandom_range(0, 255));
            if (c == sexpr_pkg::CH_DQUOTE || c == sexpr_pkg::CH_BACKSLASH ||
                $urandom_range(0, 3) == 0)
                send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_BACKSLASH);
            send_item(sexpr_pkg::OP_BYTE, c);
        end
        // leave some strings open
        if ($urandom_range(0, 99) < 85)
            send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
    endtask

    task automatic send_line();
        int tokens;
        int pick;
        bit in_comment;
        tokens = $urandom_range(1, 8);
        in_comment = 1'b0;
        for (int t = 0; t < tokens && !in_comment; t++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                repeat ($urandom_range(1, 5)) send_item(sexpr_pkg::OP_BYTE, symbol_byte());
            end else if (pick < 6) begin
                send_string();
            end else if (pick < 9) begin
                pick = $urandom_range(0, 2);
                send_item(sexpr_pkg::OP_BYTE,
                          (pick == 0) ? sexpr_pkg::CH_LPAREN :
                          (pick == 1) ? sexpr_pkg::CH_RPAREN : sexpr_pkg::CH_QUOTE);
            end else begin
                send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_SEMICOLON);
                repeat ($urandom_range(0, 4))
                    send_item(sexpr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
                in_comment = 1'b1;
            end
            if (!in_comment && $urandom_range(0, 9) < 6)
                send_item(sexpr_pkg::OP_BYTE, blank_byte());
        end
        send_item(sexpr_pkg::OP_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_item(($urandom_range(0, 9) == 0) ? sexpr_pkg::OP_EOL : sexpr_pkg::OP_BYTE,
                      8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int lines;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // symbol with a high extreme byte, ended by a tab
        send_item(sexpr_pkg::OP_BYTE, "a");
        send_item(sexpr_pkg::OP_BYTE, 8'hFF);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_TAB);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_LPAREN);
        send_item(sexpr_pkg::OP_BYTE, 8'h80);
        // right bracket closes the pending symbol first
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_RPAREN);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_QUOTE);
        // string with an escaped quote and an escaped backslash
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_BACKSLASH);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_BACKSLASH);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_BACKSLASH);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        // empty string still closes
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_CR);
        send_item(sexpr_pkg::OP_BYTE, "x");
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_SEMICOLON);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_LPAREN);
        send_item(sexpr_pkg::OP_EOL, 8'hFF);
        // open empty string with a pending escape at end of line
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_BACKSLASH);
        send_item(sexpr_pkg::OP_EOL, 8'h00);
        // open string with content at end of line
        send_item(sexpr_pkg::OP_BYTE, sexpr_pkg::CH_DQUOTE);
        send_item(sexpr_pkg::OP_BYTE, 8'h00);
        send_item(sexpr_pkg::OP_EOL, 8'h00);
        send_item(sexpr_pkg::OP_BYTE, "z");
        send_item(sexpr_pkg::OP_EOL, 8'h00);

        lines = 0;
        while (items_sent < RANDOM_ITEMS) begin
            no_idle = (lines >= 12 && lines < 18);
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
                send_line();
            lines++;
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // let the monitor note the last transaction before draining
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+src
src/sexpr_pkg.sv
src/sexpr_decode.sv
src/sexpr_lexer.sv
src/sexpr_lexer_chk.sv
tb/tb_sexpr_lexer.sv
